[rtl/byte_stream_cipher_permute_xor_assert.svh]
// Assertion macros for the byte stream cipher block.
`ifndef BYTE_STREAM_CIPHER_PERMUTE_XOR_ASSERT_SVH
`define BYTE_STREAM_CIPHER_PERMUTE_XOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bscpx_pkg.sv]
// ---------------------------------------------------------------------------
// bscpx_pkg
// Shared types and constants for the byte stream cipher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package bscpx_pkg;

    localparam int KEY_ONE_BYTES = 16;
    localparam int KEY_TWO_BYTES = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int DIV_STEPS     = 32;

    // Key-two index: the signed sum is biased by a common multiple of every
    // key-two length (1 to 8), so it stays positive and keeps its remainder.
    localparam int                    KIDX_STEPS = 10;
    localparam logic [KIDX_STEPS-1:0] KIDX_BIAS  = 10'd840;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_ONE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ONE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ONE_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_TWO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_TWO_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISORS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 3'd7;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_MIX, ST_IDX1, ST_IDX2, ST_IDX3, ST_KEYS,
        ST_DIV_START, ST_DIV_RUN, ST_DIV_NEXT, ST_FINISH, ST_OUT
    } t_state;

    // Controller commands to the datapath.
    typedef struct packed {
        logic accept;      // latch input item, load seed if starting
        logic mul1;        // products stage 1
        logic mul2;        // products stage 2
        logic mix;         // new mixing word
        logic idx1;        // start key-one index remainder
        logic idx2;        // latch key-one byte, start key-two index remainder
        logic keys;        // keystream byte
        logic div_start;   // load divider with current divisor
        logic div_step;    // one restoring step
        logic div_next;    // store remainder, advance divisor
        logic finish;      // update state, form output
    } t_cmd;

    typedef struct packed {
        logic       xt_zero;
        logic       div_done;
        logic [1:0] div_sel;
    } t_status;

    function automatic logic [7:0] permute(input logic [7:0] d, input logic [1:0] mode,
                                           input logic inv);
        logic [7:0] r;
        unique case (mode)
            2'd0: r = {d[3:0], d[7:4]};
            2'd1: r = inv ? {d[1:0], d[7:2]} : {d[5:0], d[7:6]};
            2'd2: r = ((d & 8'h33) << 2) | ((d & 8'hCC) >> 2);
            default: r = inv ? {d[2:0], d[7:3]} : {d[4:0], d[7:5]};
        endcase
        return r;
    endfunction

endpackage

[rtl/bscpx_ctrl.sv]
// ---------------------------------------------------------------------------
// bscpx_ctrl
// Sequencer for one item: multiply, mix, index, keystream, reload, output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module bscpx_ctrl
    import bscpx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = ST_MIX;
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state = ST_IDX1;
            end
            ST_IDX1: begin
                o_cmd.idx1 = 1'b1;
                n_state = ST_IDX2;
            end
            ST_IDX2: begin
                // wait for key-one remainder
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_step = 1'b0;
                    o_cmd.idx2 = 1'b1;
                    n_state = ST_IDX3;
                end
            end
            ST_IDX3: begin
                // wait for key-two remainder
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_step = 1'b0;
                    n_state = ST_KEYS;
                end
            end
            ST_KEYS: begin
                o_cmd.keys = 1'b1;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.xt_zero && i_status.div_sel != 2'd3) begin
                    n_state = ST_DIV_START;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_step = 1'b0;
                    n_state = ST_DIV_NEXT;
                end
            end
            ST_DIV_NEXT: begin
                o_cmd.div_next = 1'b1;
                n_state = ST_FINISH;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[rtl/bscpx_datapath.sv]
// ---------------------------------------------------------------------------
// bscpx_datapath
// Configuration, cipher state, multipliers and shared remainder unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module bscpx_datapath
    import bscpx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_item,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output t_out_item             o_out_item
);

    logic [63:0] r_k1_lo, r_k1_hi, r_k2;
    logic [4:0]  r_k1_len;
    logic [3:0]  r_k2_len;
    logic [31:0] r_seed;
    logic [23:0] r_div;
    logic        r_dir;

    logic [31:0] r_pos, r_mix;
    logic [7:0]  r_ka, r_kb, r_sb;
    logic        r_start;

    logic [7:0]  r_din;
    logic        r_last;
    logic [31:0] r_i, r_ii, r_bii, r_ai, r_mixn;
    logic [7:0]  r_x1b, r_x2b, r_xt, r_ra, r_rb;
    logic [7:0]  r_dout;
    logic [1:0]  r_sel;

    // shared restoring divider: 32-bit dividend, 8-bit divisor
    logic [31:0] r_dq;
    logic [8:0]  r_drem;
    logic [7:0]  r_dvs;
    logic [5:0]  r_dcnt;
    // second lane on the same dividend bits: remainder by the key-two length
    logic [2:0]  r_drem2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1_lo <= '0; r_k1_hi <= '0; r_k2 <= '0;
            r_k1_len <= 5'd1; r_k2_len <= 4'd1;
            r_seed <= '0; r_div <= '0; r_dir <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY_ONE_LOW:  r_k1_lo  <= i_cfg_data;
                REG_KEY_ONE_HIGH: r_k1_hi  <= i_cfg_data;
                REG_KEY_ONE_LEN:  r_k1_len <= i_cfg_data[4:0];
                REG_KEY_TWO:      r_k2     <= i_cfg_data;
                REG_KEY_TWO_LEN:  r_k2_len <= i_cfg_data[3:0];
                REG_SEED:         r_seed   <= i_cfg_data[31:0];
                REG_DIVISORS:     r_div    <= i_cfg_data[23:0];
                default:          r_dir    <= i_cfg_data[0];
            endcase
        end
    end

    logic [4:0] len1;
    logic [3:0] len2;
    always_comb begin
        len1 = (r_k1_len == 5'd0) ? 5'd1 :
               (r_k1_len > 5'(KEY_ONE_BYTES)) ? 5'(KEY_ONE_BYTES) : r_k1_len;
        len2 = (r_k2_len == 4'd0) ? 4'd1 :
               (r_k2_len > 4'(KEY_TWO_BYTES)) ? 4'(KEY_TWO_BYTES) : r_k2_len;
    end

    logic [31:0] a_ext, b_ext, asr;
    assign a_ext = {{24{r_ka[7]}}, r_ka};
    assign b_ext = {{24{r_kb[7]}}, r_kb};
    assign asr   = $unsigned($signed(r_mix) >>> r_ka[2:0]);

    logic [7:0] x1_sel, dsel, dmag;
    logic [3:0] idx1;
    assign idx1   = r_drem[3:0];
    assign x1_sel = idx1[3] ? r_k1_hi[8*idx1[2:0] +: 8] : r_k1_lo[8*idx1[2:0] +: 8];
    always_comb begin
        unique case (r_sel)
            2'd0: dsel = r_div[7:0];
            2'd1: dsel = r_div[15:8];
            default: dsel = r_div[23:16];
        endcase
        dmag = dsel[7] ? 8'(-dsel) : dsel;
    end

    // key-two index: (i + sext(x1b)) mod len2, taken from (i mod len2) plus
    // the signed key byte plus the bias, then reduced by a short divider run.
    logic [KIDX_STEPS-1:0] t2u;
    assign t2u = KIDX_BIAS + {{(KIDX_STEPS-3){1'b0}}, r_drem2}
               + {{(KIDX_STEPS-8){x1_sel[7]}}, x1_sel};

    logic [7:0] x0, x3, xt;
    assign x0 = r_mixn[31:24] ^ r_mixn[23:16] ^ r_mixn[15:8] ^ r_mixn[7:0];
    assign x3 = 8'(r_mixn[31:3] + {r_sb, 1'b0});
    assign xt = x0 ^ r_x1b ^ r_k2[8*r_drem[2:0] +: 8] ^ x3;

    logic [8:0] trial;
    assign trial = {r_drem[7:0], r_dq[31]} - {1'b0, r_dvs};
    logic [4:0] trial2;
    assign trial2 = {1'b0, r_drem2, r_dq[31]} - {1'b0, len2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
            r_dcnt  <= '0;
            r_sel   <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_din  <= i_in_item.data_in;
                r_last <= i_in_item.last_byte;
                if (r_start) begin
                    r_pos <= '0;
                    r_ka  <= r_seed[7:0];
                    r_kb  <= r_seed[15:8];
                    r_sb  <= r_seed[23:16];
                    r_mix <= {{24{r_seed[31]}}, r_seed[31:24]};
                    r_start <= 1'b0;
                end
            end
            if (i_cmd.mul1) begin
                r_i  <= r_pos;
                r_ii <= r_pos * r_pos;
                r_ai <= a_ext * r_pos;
            end
            if (i_cmd.mul2) r_bii <= b_ext * r_ii;
            if (i_cmd.mix) begin
                r_mixn <= r_bii + r_ai + asr;
            end
            if (i_cmd.idx1) begin
                r_dq    <= r_i;
                r_drem  <= '0;
                r_drem2 <= '0;
                r_dvs   <= {3'd0, len1};
                r_dcnt  <= 6'(DIV_STEPS);
                r_sel   <= '0;
            end
            if (i_cmd.div_start) begin
                r_dq   <= r_i;
                r_drem <= '0;
                r_dvs  <= dmag;
                r_dcnt <= 6'(DIV_STEPS);
            end
            if (i_cmd.div_step && r_dcnt != 6'd0) begin
                r_dq    <= {r_dq[30:0], 1'b0};
                r_drem  <= trial[8] ? {r_drem[7:0], r_dq[31]} : trial;
                r_drem2 <= trial2[4] ? {r_drem2[1:0], r_dq[31]} : trial2[2:0];
                r_dcnt  <= r_dcnt - 6'd1;
            end
            if (i_cmd.idx2) begin
                r_x1b  <= x1_sel;
                r_dq   <= {t2u, {(32-KIDX_STEPS){1'b0}}};
                r_drem <= '0;
                r_dvs  <= {4'd0, len2};
                r_dcnt <= 6'(KIDX_STEPS);
            end
            if (i_cmd.keys) begin
                r_x2b <= r_k2[8*r_drem[2:0] +: 8];
                r_xt  <= xt;
            end
            if (i_cmd.div_next) begin
                unique case (r_sel)
                    2'd0: r_xt <= (dsel == 8'd0) ? 8'd0 : r_drem[7:0];
                    2'd1: r_ra <= (dsel == 8'd0) ? 8'd0 : r_drem[7:0];
                    default: r_rb <= (dsel == 8'd0) ? 8'd0 : r_drem[7:0];
                endcase
                r_sel <= r_sel + 2'd1;
            end
            if (i_cmd.finish) begin
                r_ka  <= (r_sel == 2'd3) ? r_ra : r_x1b;
                r_kb  <= (r_sel == 2'd3) ? r_rb : r_x2b;
                r_sb  <= r_xt;
                r_mix <= r_mixn;
                r_pos <= r_i + 32'd1;
                r_dout <= r_dir ? permute(r_din ^ r_xt, r_mixn[1:0], 1'b1)
                                : permute(r_din, r_mixn[1:0], 1'b0) ^ r_xt;
                if (r_last) r_start <= 1'b1;
                r_sel <= '0;
            end
        end
    end

    assign o_status.xt_zero  = (r_xt == 8'd0) || (r_sel != 2'd0);
    assign o_status.div_done = (r_dcnt == 6'd0);
    assign o_status.div_sel  = r_sel;
    assign o_out_item.data_out = r_dout;
    assign o_out_item.last_out = r_last;

endmodule

[rtl/byte_stream_cipher_permute_xor.sv]
// ---------------------------------------------------------------------------
// byte_stream_cipher_permute_xor
// Byte stream cipher with keyed mixing word, bit permutation and XOR.
// ---------------------------------------------------------------------------
// One item at a time: a new item is taken only after the result of the
// previous one has been taken. A zero keystream byte starts a reload. The
// time is set by the shared restoring remainder unit: 32 steps for the
// key-one index, 10 steps for the key-two index and, on a reload, 32 steps
// for each of the three divisors. An output stall holds the result until taken.
`timescale 1ns / 1ps
`include "byte_stream_cipher_permute_xor_assert.svh"
module byte_stream_cipher_permute_xor
    import bscpx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    t_cmd    cmd;
    t_status status;

    bscpx_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .i_status(status), .o_cmd(cmd)
    );

    bscpx_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_in_item,
        .i_cmd(cmd), .o_status(status), .o_out_item
    );

    // Never take an item while a result is pending.
    `BSC_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_out_valid, o_in_stall, "overlap")
    // Accepted item is followed by work, not an immediate result.
    `BSC_ASSERT_NEXT(a_no_instant, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        !o_out_valid, "instant result")

endmodule
